// ===== hdl/controlled_qubit_rotation_apply_assert.svh =====
// Assertion macros used by the checker file of the rotation block
`ifndef CONTROLLED_QUBIT_ROTATION_APPLY_ASSERT_SVH
`define CONTROLLED_QUBIT_ROTATION_APPLY_ASSERT_SVH

// same-cycle implication, masked during reset
`define CQRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, live during reset
`define CQRA_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/cqra_pkg.sv =====
// Shared widths, register map and types of the controlled rotation block
package cqra_pkg;

    localparam int STATE_QUBITS_DEF = 20;
    localparam int PAIR_W           = 19;
    localparam int ROW_W            = 20;
    localparam int AMP_W            = 16;
    localparam int BIT_W            = 5;
    localparam int CFG_W            = 64;
    localparam int ADDR_W           = 6;
    localparam int IDX_W            = 3;
    localparam int IN_TDATA_W       = 88;
    localparam int OUT_TDATA_W      = 104;
    localparam int PROD_W           = 2 * AMP_W;
    localparam int SUM_W            = PROD_W + 2;

    localparam logic [IDX_W-1:0] REG_SET_ROW0   = 3'd0;
    localparam logic [IDX_W-1:0] REG_SET_ROW1   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLEAR_ROW0 = 3'd2;
    localparam logic [IDX_W-1:0] REG_CLEAR_ROW1 = 3'd3;
    localparam logic [IDX_W-1:0] REG_TARGET     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CONTROL    = 3'd5;

    localparam logic [CFG_W-1:0] ROW0_RESET    = 64'd16384;
    localparam logic [CFG_W-1:0] ROW1_RESET    = 64'd70368744177664;
    localparam logic [BIT_W-1:0] TARGET_RESET  = 5'd0;
    localparam logic [BIT_W-1:0] CONTROL_RESET = 5'd1;

    typedef struct packed {
        logic [ROW_W-1:0] lower;
        logic [ROW_W-1:0] upper;
        logic             ctl;
    } t_rows;

endpackage

// ===== hdl/cqra_row_map.sv =====
// Row index expansion around the target bit and control bit lookup
module cqra_row_map #(
    parameter int STATE_QUBITS = cqra_pkg::STATE_QUBITS_DEF
) (
    input  logic [cqra_pkg::PAIR_W-1:0] i_pair,
    input  logic [cqra_pkg::BIT_W-1:0]  i_target,
    input  logic [cqra_pkg::BIT_W-1:0]  i_control,
    output cqra_pkg::t_rows             o_rows
);

    localparam int KEEP = (STATE_QUBITS - 1 < cqra_pkg::PAIR_W) ?
                          STATE_QUBITS - 1 : cqra_pkg::PAIR_W;

    logic [cqra_pkg::PAIR_W-1:0] w_pair;
    logic [cqra_pkg::ROW_W-1:0]  w_pair_lo;
    logic [cqra_pkg::ROW_W-1:0]  w_pair_sh;
    logic [cqra_pkg::BIT_W-1:0]  w_target;

    always_comb begin
        for (int i = 0; i < cqra_pkg::PAIR_W; i++) begin
            w_pair[i] = (i < KEEP) ? i_pair[i] : 1'b0;
        end
        w_pair_lo = {1'b0, w_pair};
        w_pair_sh = {w_pair, 1'b0};
        w_target  = ({1'b0, i_target} >= 6'(STATE_QUBITS)) ?
                    cqra_pkg::BIT_W'(STATE_QUBITS - 1) : i_target;
    end

    always_comb begin
        o_rows.ctl = 1'b0;
        for (int i = 0; i < cqra_pkg::ROW_W; i++) begin
            if (cqra_pkg::BIT_W'(i) < w_target) begin
                o_rows.lower[i] = w_pair_lo[i];
            end else if (cqra_pkg::BIT_W'(i) == w_target) begin
                o_rows.lower[i] = 1'b0;
            end else begin
                o_rows.lower[i] = w_pair_sh[i];
            end
            o_rows.upper[i] = o_rows.lower[i] | (cqra_pkg::BIT_W'(i) == w_target);
        end
        for (int i = 0; i < cqra_pkg::ROW_W; i++) begin
            if (i < STATE_QUBITS && i_control == cqra_pkg::BIT_W'(i)) begin
                o_rows.ctl = o_rows.lower[i];
            end
        end
    end

endmodule

// ===== hdl/controlled_qubit_rotation_apply.sv =====
// Top level: controlled 2x2 complex rotation applied to streamed amplitude pairs
//
// Input stream carries one amplitude pair per transaction: the pair number and
// the lower and upper complex amplitudes (Q1.14). Output stream returns the two
// state row indices and the rotated amplitudes, rounded and saturated.
// The APB port holds both 2x2 matrices and the target and control positions;
// write it only while no transaction is in flight.
// Three register stages: input, products (sixteen 16x16 multipliers), and
// sum, round and saturate. A transaction moves through the input, product and
// result registers in order. While the receiver takes results, one transaction
// is taken per cycle, set by the three-stage pipeline with one product per
// multiplier each cycle. When the receiver stalls, the result holds and the
// emptier stages keep filling; input tready drops only once every stage holds
// a transaction. Reset empties the pipeline and restores identity matrices,
// target zero and control one.
module controlled_qubit_rotation_apply #(
    parameter int STATE_QUBITS = cqra_pkg::STATE_QUBITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pair_number, lower_real, lower_imag, upper_real, upper_imag, zero pad
    input  logic [cqra_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // lower_row, upper_row, new_lower_real, new_lower_imag,
    // new_upper_real, new_upper_imag
    output logic [cqra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cqra_pkg::ADDR_W-1:0]       paddr,
    input  logic [cqra_pkg::CFG_W-1:0]        pwdata,
    output logic [cqra_pkg::CFG_W-1:0]        prdata,
    output logic                              pready
);

    function automatic logic signed [cqra_pkg::AMP_W-1:0] round_sat(
        input logic signed [cqra_pkg::SUM_W-1:0] s
    );
        logic signed [cqra_pkg::SUM_W:0] b;
        logic signed [cqra_pkg::SUM_W-14:0] q;
        b = (cqra_pkg::SUM_W+1)'(s) + 35'sd8192;
        q = signed'(b[cqra_pkg::SUM_W:14]);
        if (q > 21'sd32767) begin
            return 16'sh7fff;
        end else if (q < -21'sd32768) begin
            return 16'sh8000;
        end else begin
            return signed'(q[cqra_pkg::AMP_W-1:0]);
        end
    endfunction

    logic [cqra_pkg::CFG_W-1:0] r_set_row0;
    logic [cqra_pkg::CFG_W-1:0] r_set_row1;
    logic [cqra_pkg::CFG_W-1:0] r_clear_row0;
    logic [cqra_pkg::CFG_W-1:0] r_clear_row1;
    logic [cqra_pkg::BIT_W-1:0] r_target;
    logic [cqra_pkg::BIT_W-1:0] r_control;
    logic                       w_cfg_wr;
    logic [cqra_pkg::IDX_W-1:0] w_idx;

    logic w_rdy1, w_rdy2, w_rdy3;
    logic r_v1, r_v2, r_v3;

    logic [cqra_pkg::PAIR_W-1:0]       r_pair;
    logic signed [cqra_pkg::AMP_W-1:0] r_amp [4];

    cqra_pkg::t_rows                    w_rows;
    logic [cqra_pkg::CFG_W-1:0]         w_row0;
    logic [cqra_pkg::CFG_W-1:0]         w_row1;
    logic signed [cqra_pkg::AMP_W-1:0]  w_m [8];
    logic signed [cqra_pkg::PROD_W-1:0] n_prod [16];
    logic signed [cqra_pkg::PROD_W-1:0] r_prod [16];
    logic [cqra_pkg::ROW_W-1:0]         r_lower2, r_upper2;

    logic signed [cqra_pkg::SUM_W-1:0]  n_sum [4];
    logic signed [cqra_pkg::AMP_W-1:0]  r_res [4];
    logic [cqra_pkg::ROW_W-1:0]         r_lower3, r_upper3;

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_idx    = paddr[cqra_pkg::ADDR_W-1:cqra_pkg::ADDR_W-cqra_pkg::IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_row0   <= cqra_pkg::ROW0_RESET;
            r_set_row1   <= cqra_pkg::ROW1_RESET;
            r_clear_row0 <= cqra_pkg::ROW0_RESET;
            r_clear_row1 <= cqra_pkg::ROW1_RESET;
            r_target     <= cqra_pkg::TARGET_RESET;
            r_control    <= cqra_pkg::CONTROL_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                cqra_pkg::REG_SET_ROW0:   r_set_row0   <= pwdata;
                cqra_pkg::REG_SET_ROW1:   r_set_row1   <= pwdata;
                cqra_pkg::REG_CLEAR_ROW0: r_clear_row0 <= pwdata;
                cqra_pkg::REG_CLEAR_ROW1: r_clear_row1 <= pwdata;
                cqra_pkg::REG_TARGET:     r_target     <= pwdata[cqra_pkg::BIT_W-1:0];
                cqra_pkg::REG_CONTROL:    r_control    <= pwdata[cqra_pkg::BIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            cqra_pkg::REG_SET_ROW0:   prdata = r_set_row0;
            cqra_pkg::REG_SET_ROW1:   prdata = r_set_row1;
            cqra_pkg::REG_CLEAR_ROW0: prdata = r_clear_row0;
            cqra_pkg::REG_CLEAR_ROW1: prdata = r_clear_row1;
            cqra_pkg::REG_TARGET:     prdata = cqra_pkg::CFG_W'(r_target);
            cqra_pkg::REG_CONTROL:    prdata = cqra_pkg::CFG_W'(r_control);
            default:                  prdata = '0;
        endcase
    end

    // pipeline flow control
    assign w_rdy3        = !r_v3 || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;
    assign m_axis_tvalid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage 1: capture input
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && s_axis_tvalid) begin
            r_pair   <= s_axis_tdata[18:0];
            r_amp[0] <= signed'(s_axis_tdata[34:19]);
            r_amp[1] <= signed'(s_axis_tdata[50:35]);
            r_amp[2] <= signed'(s_axis_tdata[66:51]);
            r_amp[3] <= signed'(s_axis_tdata[82:67]);
        end
    end

    // stage 2: rows, matrix select, products
    cqra_row_map #(
        .STATE_QUBITS (STATE_QUBITS)
    ) u_row_map (
        .i_pair    (r_pair),
        .i_target  (r_target),
        .i_control (r_control),
        .o_rows    (w_rows)
    );

    assign w_row0 = w_rows.ctl ? r_set_row0 : r_clear_row0;
    assign w_row1 = w_rows.ctl ? r_set_row1 : r_clear_row1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_m[k]     = signed'(w_row0[16*k +: cqra_pkg::AMP_W]);
            w_m[k + 4] = signed'(w_row1[16*k +: cqra_pkg::AMP_W]);
        end
        for (int r = 0; r < 2; r++) begin
            n_prod[8*r + 0] = cqra_pkg::PROD_W'(w_m[4*r + 0]) * cqra_pkg::PROD_W'(r_amp[0]);
            n_prod[8*r + 1] = cqra_pkg::PROD_W'(w_m[4*r + 1]) * cqra_pkg::PROD_W'(r_amp[1]);
            n_prod[8*r + 2] = cqra_pkg::PROD_W'(w_m[4*r + 2]) * cqra_pkg::PROD_W'(r_amp[2]);
            n_prod[8*r + 3] = cqra_pkg::PROD_W'(w_m[4*r + 3]) * cqra_pkg::PROD_W'(r_amp[3]);
            n_prod[8*r + 4] = cqra_pkg::PROD_W'(w_m[4*r + 0]) * cqra_pkg::PROD_W'(r_amp[1]);
            n_prod[8*r + 5] = cqra_pkg::PROD_W'(w_m[4*r + 1]) * cqra_pkg::PROD_W'(r_amp[0]);
            n_prod[8*r + 6] = cqra_pkg::PROD_W'(w_m[4*r + 2]) * cqra_pkg::PROD_W'(r_amp[3]);
            n_prod[8*r + 7] = cqra_pkg::PROD_W'(w_m[4*r + 3]) * cqra_pkg::PROD_W'(r_amp[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_prod   <= n_prod;
            r_lower2 <= w_rows.lower;
            r_upper2 <= w_rows.upper;
        end
    end

    // stage 3: sum, round, saturate
    always_comb begin
        for (int r = 0; r < 2; r++) begin
            n_sum[2*r]     = cqra_pkg::SUM_W'(r_prod[8*r + 0])
                           - cqra_pkg::SUM_W'(r_prod[8*r + 1])
                           + cqra_pkg::SUM_W'(r_prod[8*r + 2])
                           - cqra_pkg::SUM_W'(r_prod[8*r + 3]);
            n_sum[2*r + 1] = cqra_pkg::SUM_W'(r_prod[8*r + 4])
                           + cqra_pkg::SUM_W'(r_prod[8*r + 5])
                           + cqra_pkg::SUM_W'(r_prod[8*r + 6])
                           + cqra_pkg::SUM_W'(r_prod[8*r + 7]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            for (int k = 0; k < 4; k++) begin
                r_res[k] <= round_sat(n_sum[k]);
            end
            r_lower3 <= r_lower2;
            r_upper3 <= r_upper2;
        end
    end

    assign m_axis_tdata = {r_res[3], r_res[2], r_res[1], r_res[0], r_upper3, r_lower3};

endmodule

// ===== hdl/cqra_checker.sv =====
// Port-level checker for the controlled rotation block, bound to the top level
`include "controlled_qubit_rotation_apply_assert.svh"

module cqra_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cqra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             pready
);

    logic [cqra_pkg::ROW_W-1:0] w_lower;
    logic [cqra_pkg::ROW_W-1:0] w_upper;

    assign w_lower = m_axis_tdata[cqra_pkg::ROW_W-1:0];
    assign w_upper = m_axis_tdata[2*cqra_pkg::ROW_W-1:cqra_pkg::ROW_W];

    `CQRA_ASSERT_NXT(a_reset_empties, i_clk, !i_rst_n, !m_axis_tvalid)
    `CQRA_ASSERT_IMP(a_empty_takes_input, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready && pready)
    `CQRA_ASSERT_IMP(a_upper_covers_lower, i_clk, i_rst_n, m_axis_tvalid, (w_upper & w_lower) == w_lower)
    `CQRA_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n && m_axis_tvalid && !m_axis_tready, !i_rst_n || (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind controlled_qubit_rotation_apply cqra_checker u_cqra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the controlled qubit rotation block: APB setup, stream traffic
module tb;
    import cqra_pkg::*;

    localparam int QUBITS = STATE_QUBITS_DEF;

    typedef struct packed {
        logic [4:0]        pad;
        logic [AMP_W-1:0]  upper_imag;
        logic [AMP_W-1:0]  upper_real;
        logic [AMP_W-1:0]  lower_imag;
        logic [AMP_W-1:0]  lower_real;
        logic [PAIR_W-1:0] pair_number;
    } pair_item_t;

    typedef struct packed {
        logic [AMP_W-1:0] new_upper_imag;
        logic [AMP_W-1:0] new_upper_real;
        logic [AMP_W-1:0] new_lower_imag;
        logic [AMP_W-1:0] new_lower_real;
        logic [ROW_W-1:0] upper_row;
        logic [ROW_W-1:0] lower_row;
    } rotated_item_t;

    class rotation_scoreboard;
        logic [CFG_W-1:0] set_row0, set_row1, clear_row0, clear_row1;
        logic [BIT_W-1:0] target_pos, control_pos;
        rotated_item_t    rotated_q[$];
        int               mismatches;

        function new();
            set_row0    = ROW0_RESET;
            set_row1    = ROW1_RESET;
            clear_row0  = ROW0_RESET;
            clear_row1  = ROW1_RESET;
            target_pos  = TARGET_RESET;
            control_pos = CONTROL_RESET;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SET_ROW0:   set_row0 = val;
                REG_SET_ROW1:   set_row1 = val;
                REG_CLEAR_ROW0: clear_row0 = val;
                REG_CLEAR_ROW1: clear_row1 = val;
                REG_TARGET:     target_pos = val[BIT_W-1:0];
                REG_CONTROL:    control_pos = val[BIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction

        function logic [AMP_W-1:0] round_q14(logic signed [39:0] acc);
            logic signed [39:0] r;
            r = (acc + 40'sd8192) >>> 14;
            if (r > 40'sd32767) return 16'h7fff;
            if (r < -40'sd32768) return 16'h8000;
            return r[AMP_W-1:0];
        endfunction

        function void note_pair(pair_item_t d);
            int unsigned        t;
            logic [31:0]        p, lower, upper;
            logic               ctl;
            logic [CFG_W-1:0]   r0, r1;
            logic signed [15:0] lr, li, ur, ui, ar, ai, br, bi, cr, ci, dr, di;
            logic signed [39:0] acc;
            rotated_item_t      want;
            t = (target_pos >= QUBITS) ? QUBITS - 1 : target_pos;
            p = {13'd0, d.pair_number};
            lower = ((p >> t) << (t + 1)) | (p & ((32'd1 << t) - 32'd1));
            upper = lower | (32'd1 << t);
            ctl = (control_pos < QUBITS) && lower[control_pos];
            r0 = ctl ? set_row0 : clear_row0;
            r1 = ctl ? set_row1 : clear_row1;
            lr = d.lower_real;
            li = d.lower_imag;
            ur = d.upper_real;
            ui = d.upper_imag;
            {bi, br, ai, ar} = r0;
            {di, dr, ci, cr} = r1;
            want.lower_row = lower[ROW_W-1:0];
            want.upper_row = upper[ROW_W-1:0];
            acc = 40'(ar) * 40'(lr) - 40'(ai) * 40'(li) + 40'(br) * 40'(ur) - 40'(bi) * 40'(ui);
            want.new_lower_real = round_q14(acc);
            acc = 40'(ar) * 40'(li) + 40'(ai) * 40'(lr) + 40'(br) * 40'(ui) + 40'(bi) * 40'(ur);
            want.new_lower_imag = round_q14(acc);
            acc = 40'(cr) * 40'(lr) - 40'(ci) * 40'(li) + 40'(dr) * 40'(ur) - 40'(di) * 40'(ui);
            want.new_upper_real = round_q14(acc);
            acc = 40'(cr) * 40'(li) + 40'(ci) * 40'(lr) + 40'(dr) * 40'(ui) + 40'(di) * 40'(ur);
            want.new_upper_imag = round_q14(acc);
            rotated_q.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            mismatches++;
        endtask

        task check_field(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task check_result(rotated_item_t got);
            rotated_item_t want;
            if (rotated_q.size() == 0) begin
                report_mismatch("unexpected transaction", got[31:0], 32'd0);
                return;
            end
            want = rotated_q.pop_front();
            check_field("lower_row", 32'(got.lower_row), 32'(want.lower_row));
            check_field("upper_row", 32'(got.upper_row), 32'(want.upper_row));
            check_field("new_lower_real", 32'(got.new_lower_real), 32'(want.new_lower_real));
            check_field("new_lower_imag", 32'(got.new_lower_imag), 32'(want.new_lower_imag));
            check_field("new_upper_real", 32'(got.new_upper_real), 32'(want.new_upper_real));
            check_field("new_upper_imag", 32'(got.new_upper_imag), 32'(want.new_upper_imag));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [CFG_W-1:0]       pwdata = '0;
    logic [CFG_W-1:0]       prdata;
    logic                   pready;

    rotation_scoreboard sb;
    logic               steady = 1'b0;

    controlled_qubit_rotation_apply dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
    end

    function automatic logic [AMP_W-1:0] pick_amp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4, 5: return 16'($urandom_range(0, 16383) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [AMP_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;
            3: return 16'hc000;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_row();
        return {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
    endfunction

    function automatic logic [CFG_W-1:0] pack_row(logic [15:0] ar, ai, br, bi);
        return {bi, br, ai, ar};
    endfunction

    function automatic pair_item_t make_pair(logic [PAIR_W-1:0] p,
                                             logic [15:0] lr, li, ur, ui);
        pair_item_t d;
        d.pad         = '0;
        d.pair_number = p;
        d.lower_real  = lr;
        d.lower_imag  = li;
        d.upper_real  = ur;
        d.upper_imag  = ui;
        return d;
    endfunction

    function automatic pair_item_t random_pair();
        logic [PAIR_W-1:0] p;
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            default: p = PAIR_W'($urandom);
        endcase
        return make_pair(p, pick_amp(), pick_amp(), pick_amp(), pick_amp());
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
    endtask

    task automatic program_gate(input logic [CFG_W-1:0] s0, s1, c0, c1,
                                input logic [BIT_W-1:0] tgt, ctl);
        write_reg(REG_SET_ROW0, s0);
        write_reg(REG_SET_ROW1, s1);
        write_reg(REG_CLEAR_ROW0, c0);
        write_reg(REG_CLEAR_ROW1, c1);
        write_reg(REG_TARGET, {59'd0, tgt});
        write_reg(REG_CONTROL, {59'd0, ctl});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pair(input pair_item_t d);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pair(d);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        int               ph;
        logic [BIT_W-1:0] tgt, ctl;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(make_pair('0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_pair(make_pair('1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_pair(make_pair(19'h55555, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_pair(make_pair(19'h2aaaa, 16'h8000, 16'h7fff, 16'h4000, 16'hc000));
        drain();

        program_gate({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 5'd19, 5'd0);
        send_pair(make_pair('1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
        send_pair(make_pair(19'd1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        send_pair(make_pair('0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        drain();

        program_gate({4{16'h7fff}}, {4{16'h8000}}, {4{16'h7fff}}, {4{16'h0000}}, 5'd31, 5'd31);
        send_pair(make_pair('1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_pair(make_pair(19'h40000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_pair(make_pair(19'd3, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff));
        drain();

        program_gate(pick_row(), pick_row(), pick_row(), pick_row(), 5'd5, 5'd5);
        repeat (3) send_pair(random_pair());
        drain();

        program_gate(pack_row(16'h4000, 16'h0, 16'h0, 16'h0), ROW1_RESET,
                     pack_row(16'h0001, 16'h0, 16'h0, 16'h0),
                     pack_row(16'h0, 16'h0, 16'h0001, 16'h0), 5'd7, 5'd20);
        send_pair(make_pair(19'h12345, 16'd8192, -16'sd8192, -16'sd8193, 16'd8191));
        send_pair(make_pair(19'h6789a, 16'd24576, -16'sd24576, 16'd8193, -16'sd8191));
        drain();

        for (ph = 0; ph < 16; ph++) begin
            steady = (ph >= 6 && ph < 9);
            tgt = (ph % 5 == 0) ? 5'd19 : 5'($urandom_range(0, 31));
            ctl = (ph % 3 == 0) ? tgt : 5'($urandom_range(0, 31));
            program_gate(pick_row(), pick_row(), pick_row(), pick_row(), tgt, ctl);
            repeat ($urandom_range(45, 60)) send_pair(random_pair());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== controlled_qubit_rotation_apply.f =====
+incdir+hdl
hdl/cqra_pkg.sv
hdl/cqra_row_map.sv
hdl/controlled_qubit_rotation_apply.sv
hdl/cqra_checker.sv
dv/tb.sv
